@@ rtl/pcp_pkg.sv @@
// Shared types and constants for the lidar point camera projection block.
`timescale 1ns / 1ps
package pcp_pkg;

   localparam int COEF_COUNT = 12;
   localparam int CSR_BITS   = 14;
   localparam int PROD_BITS  = 48;
   localparam int SUM_BITS   = 50;
   localparam int OUT_BITS   = 48;

   typedef enum logic [0:0] {
      KIND_LOAD  = 1'b0,
      KIND_POINT = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_INSIDE  = 2'd0,
      ST_BEHIND  = 2'd1,
      ST_OUTSIDE = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   localparam logic signed [OUT_BITS-1:0] SAT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
   localparam logic signed [OUT_BITS-1:0] SAT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

endpackage

@@ rtl/pcp_if.sv @@
// Request and response channel interfaces of the projection block.
`timescale 1ns / 1ps
interface pcp_req_if;
   logic                valid;
   logic                ready;
   logic                kind;
   logic [3:0]          coef_index;
   logic signed [31:0]  coef_value;
   logic signed [31:0]  pos_x;
   logic signed [31:0]  pos_y;
   logic signed [31:0]  pos_z;

   modport source (output valid, kind, coef_index, coef_value, pos_x, pos_y, pos_z,
                   input ready);
   modport sink   (input valid, kind, coef_index, coef_value, pos_x, pos_y, pos_z,
                   output ready);
endinterface

interface pcp_rsp_if #(parameter int PIXEL_BITS = 13);
   logic                   valid;
   logic                   ready;
   logic [1:0]             status;
   logic [PIXEL_BITS-1:0]  pixel_x;
   logic [PIXEL_BITS-1:0]  pixel_y;
   logic signed [47:0]     depth_scaled;
   logic signed [47:0]     neg_u;
   logic signed [47:0]     neg_v;

   modport source (output valid, status, pixel_x, pixel_y, depth_scaled, neg_u, neg_v,
                   input ready);
   modport sink   (input valid, status, pixel_x, pixel_y, depth_scaled, neg_u, neg_v,
                   output ready);
endinterface

@@ rtl/lidar_point_camera_projection.sv @@
// Top level of the lidar point camera projection pipeline.
//
//  Channel  Direction  Moves
//  req_bus  in         coefficient loads and points to project
//  rsp_bus  out        one projection result per point request
//  csr_*    in         image width and height writes
//
// One request is taken every cycle while the response is not stalled; a point result passes
// through the input, product, sum and sign stages, the one-bit-per-stage divider and the output register.
// A coefficient load takes effect for every point request accepted after it.
// Reset clears the matrix to zero and the image size to 1920 by 1080.
// When the response is stalled the whole pipeline holds and the request side is not ready.
`timescale 1ns / 1ps
module lidar_point_camera_projection #(
   parameter int PIXEL_BITS = 13
) (
   input  logic                       clock,
   input  logic                       reset,
   pcp_req_if.sink                    req_bus,
   pcp_rsp_if.source                  rsp_bus,
   input  logic                       csr_wr_en,
   input  pcp_pkg::csr_index_type     csr_index,
   input  logic [pcp_pkg::CSR_BITS-1:0] csr_wr_data
);
   import pcp_pkg::*;

   localparam int PB = PIXEL_BITS;

   logic advance, accept;
   logic [CSR_BITS-1:0] width_ff, height_ff;
   logic signed [31:0] coef_ff [0:COEF_COUNT-1];

   logic s0_v_ff;
   logic signed [31:0] px_ff, py_ff, pz_ff;

   logic s1_v_ff;
   logic signed [PROD_BITS-1:0] prod_ff [0:8];
   logic signed [31:0] k_ff [0:2];

   logic s2_v_ff;
   logic signed [SUM_BITS-1:0] u_ff, v_ff, w_ff;

   logic s3_v_ff, s3_behind_ff, s3_un_ff, s3_vn_ff;
   logic [SUM_BITS-1:0] au_ff, av_ff, s3_w_ff;
   logic signed [OUT_BITS-1:0] s3_dep_ff, s3_nu_ff, s3_nv_ff;

   logic sb_v_ff [0:PB];
   logic sb_behind_ff [0:PB];
   logic sb_un_ff [0:PB];
   logic sb_vn_ff [0:PB];
   logic signed [OUT_BITS-1:0] sb_dep_ff [0:PB];
   logic signed [OUT_BITS-1:0] sb_nu_ff [0:PB];
   logic signed [OUT_BITS-1:0] sb_nv_ff [0:PB];

   logic [PB-1:0] qx, qy;
   logic ovx, ovy, outside;

   logic out_v_ff;
   logic [1:0] status_ff;
   logic [PB-1:0] pix_x_ff, pix_y_ff;
   logic signed [OUT_BITS-1:0] dep_ff, nu_ff, nv_ff;

   function automatic logic signed [OUT_BITS-1:0] sat48(input logic signed [59:0] x);
      logic signed [59:0] hi, lo;
      hi = 60'(SAT_MAX);
      lo = 60'(SAT_MIN);
      if (x > hi) begin
         return SAT_MAX;
      end else if (x < lo) begin
         return SAT_MIN;
      end
      return x[OUT_BITS-1:0];
   endfunction

   assign advance = !out_v_ff || rsp_bus.ready;
   assign req_bus.ready = advance;
   assign accept = req_bus.valid && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CSR_BITS'(1920);
         height_ff <= CSR_BITS'(1080);
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  width_ff <= csr_wr_data;
            REG_IMAGE_HEIGHT: height_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COEF_COUNT; i++) coef_ff[i] <= '0;
      end else if (accept && req_bus.kind == KIND_LOAD && req_bus.coef_index < 4'(COEF_COUNT)) begin
         coef_ff[req_bus.coef_index] <= req_bus.coef_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff  <= 1'b0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         for (int i = 0; i <= PB; i++) sb_v_ff[i] <= 1'b0;
      end else if (advance) begin
         s0_v_ff  <= accept && req_bus.kind == KIND_POINT;
         s1_v_ff  <= s0_v_ff;
         s2_v_ff  <= s1_v_ff;
         s3_v_ff  <= s2_v_ff;
         sb_v_ff[0] <= s3_v_ff;
         for (int i = 1; i <= PB; i++) sb_v_ff[i] <= sb_v_ff[i-1];
         out_v_ff <= sb_v_ff[PB];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         px_ff <= req_bus.pos_x;
         py_ff <= req_bus.pos_y;
         pz_ff <= req_bus.pos_z;
         for (int r = 0; r < 3; r++) begin
            prod_ff[3*r]   <= 48'((64'(coef_ff[4*r])   * 64'(px_ff)) >>> 16);
            prod_ff[3*r+1] <= 48'((64'(coef_ff[4*r+1]) * 64'(py_ff)) >>> 16);
            prod_ff[3*r+2] <= 48'((64'(coef_ff[4*r+2]) * 64'(pz_ff)) >>> 16);
            k_ff[r]        <= coef_ff[4*r+3];
         end
         u_ff <= SUM_BITS'(prod_ff[0]) + SUM_BITS'(prod_ff[1]) + SUM_BITS'(prod_ff[2])
               + SUM_BITS'(k_ff[0]);
         v_ff <= SUM_BITS'(prod_ff[3]) + SUM_BITS'(prod_ff[4]) + SUM_BITS'(prod_ff[5])
               + SUM_BITS'(k_ff[1]);
         w_ff <= SUM_BITS'(prod_ff[6]) + SUM_BITS'(prod_ff[7]) + SUM_BITS'(prod_ff[8])
               + SUM_BITS'(k_ff[2]);
         s3_behind_ff <= (w_ff <= 0);
         s3_un_ff     <= u_ff[SUM_BITS-1];
         s3_vn_ff     <= v_ff[SUM_BITS-1];
         au_ff        <= u_ff[SUM_BITS-1] ? SUM_BITS'(-u_ff) : u_ff;
         av_ff        <= v_ff[SUM_BITS-1] ? SUM_BITS'(-v_ff) : v_ff;
         s3_w_ff      <= w_ff;
         s3_dep_ff    <= sat48(60'(w_ff) * 60'sd1000);
         s3_nu_ff     <= sat48(-60'(u_ff));
         s3_nv_ff     <= sat48(-60'(v_ff));
         sb_behind_ff[0] <= s3_behind_ff;
         sb_un_ff[0]     <= s3_un_ff;
         sb_vn_ff[0]     <= s3_vn_ff;
         sb_dep_ff[0]    <= s3_dep_ff;
         sb_nu_ff[0]     <= s3_nu_ff;
         sb_nv_ff[0]     <= s3_nv_ff;
         for (int i = 1; i <= PB; i++) begin
            sb_behind_ff[i] <= sb_behind_ff[i-1];
            sb_un_ff[i]     <= sb_un_ff[i-1];
            sb_vn_ff[i]     <= sb_vn_ff[i-1];
            sb_dep_ff[i]    <= sb_dep_ff[i-1];
            sb_nu_ff[i]     <= sb_nu_ff[i-1];
            sb_nv_ff[i]     <= sb_nv_ff[i-1];
         end
      end
   end

   pcp_divider #(.PB(PB), .NW(SUM_BITS)) u_div_x (
      .clock(clock), .advance(advance), .num(au_ff), .den(s3_w_ff),
      .quot(qx), .over(ovx)
   );

   pcp_divider #(.PB(PB), .NW(SUM_BITS)) u_div_y (
      .clock(clock), .advance(advance), .num(av_ff), .den(s3_w_ff),
      .quot(qy), .over(ovy)
   );

   assign outside = ovx || ovy
                 || (sb_un_ff[PB] && qx != '0) || (sb_vn_ff[PB] && qy != '0)
                 || (32'(qx) >= 32'(width_ff)) || (32'(qy) >= 32'(height_ff));

   always_ff @(posedge clock) begin
      if (advance) begin
         if (sb_behind_ff[PB]) begin
            status_ff <= ST_BEHIND;
            pix_x_ff  <= '0;
            pix_y_ff  <= '0;
            dep_ff    <= '0;
            nu_ff     <= '0;
            nv_ff     <= '0;
         end else begin
            status_ff <= outside ? ST_OUTSIDE : ST_INSIDE;
            pix_x_ff  <= outside ? '0 : qx;
            pix_y_ff  <= outside ? '0 : qy;
            dep_ff    <= sb_dep_ff[PB];
            nu_ff     <= sb_nu_ff[PB];
            nv_ff     <= sb_nv_ff[PB];
         end
      end
   end

   assign rsp_bus.valid        = out_v_ff;
   assign rsp_bus.status       = status_ff;
   assign rsp_bus.pixel_x      = pix_x_ff;
   assign rsp_bus.pixel_y      = pix_y_ff;
   assign rsp_bus.depth_scaled = dep_ff;
   assign rsp_bus.neg_u        = nu_ff;
   assign rsp_bus.neg_v        = nv_ff;

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      accept && req_bus.kind == KIND_LOAD |=> !s0_v_ff)
      else $error("load request entered the pipeline");

   a_behind_zero: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && status_ff == ST_BEHIND |-> dep_ff == '0 && pix_x_ff == '0 && nu_ff == '0)
      else $error("behind-camera result carries data");

   a_inside_bounds: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && status_ff == ST_INSIDE |->
         32'(pix_x_ff) < 32'(width_ff) && 32'(pix_y_ff) < 32'(height_ff))
      else $error("inside result beyond image size");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> status_ff == ST_INSIDE || status_ff == ST_BEHIND || status_ff == ST_OUTSIDE)
      else $error("invalid status code");
endmodule

@@ rtl/pcp_divider.sv @@
// Pipelined restoring divider giving a narrow quotient and an overflow flag.
`timescale 1ns / 1ps
module pcp_divider #(
   parameter int PB = 13,
   parameter int NW = 50
) (
   input  logic          clock,
   input  logic          advance,
   input  logic [NW-1:0] num,
   input  logic [NW-1:0] den,
   output logic [PB-1:0] quot,
   output logic          over
);
   localparam int DW = NW + PB;

   logic [DW-1:0] rem_ff [0:PB];
   logic [NW-1:0] den_ff [0:PB];
   logic [PB-1:0] quo_ff [0:PB];
   logic          ovf_ff [0:PB];

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= {{PB{1'b0}}, num};
         den_ff[0] <= den;
         quo_ff[0] <= '0;
         ovf_ff[0] <= ({{PB{1'b0}}, num} >= {den, {PB{1'b0}}});
      end
   end

   for (genvar k = 1; k <= PB; k++) begin : g_step
      localparam int SH = PB - k;
      logic [DW-1:0] trial;
      logic          fits;

      assign trial = {{PB{1'b0}}, den_ff[k-1]} << SH;
      assign fits  = rem_ff[k-1] >= trial;

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k] <= fits ? rem_ff[k-1] - trial : rem_ff[k-1];
            den_ff[k] <= den_ff[k-1];
            quo_ff[k] <= fits ? (quo_ff[k-1] | (PB'(1) << SH)) : quo_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign quot = quo_ff[PB];
   assign over = ovf_ff[PB];
endmodule
